### rtl/core/b3csh_pkg.sv
`timescale 1ns / 1ps
// Package for the chained stream hash core: constants, microcode format and ROM,
// and small helper functions. No dependencies.
package b3csh_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int BLK_AW      = $clog2(BLOCK_BYTES);
  localparam int FILL_W      = BLK_AW + 1;
  localparam int CNT_W       = BLK_AW + 1;
  localparam int DOMAIN_MAX  = 28;
  localparam int ROUNDS      = 7;
  localparam int DIGEST_MAX  = 32;
  localparam int DGB_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int PC_W        = 6;

  localparam logic [31:0] FLAG_ROOT = 32'd8;

  localparam logic [31:0] IV [4] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A};
  localparam int PERM [16] = '{2, 6, 3, 10, 7, 0, 4, 13, 1, 11, 12, 5, 9, 14, 15, 8};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_45 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_6  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOM_LEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DGST_LEN  = 3'd5;

  // datapath operations
  localparam logic [2:0] OP_WAIT  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_INIT  = 3'd2;
  localparam logic [2:0] OP_ROUND = 3'd3;
  localparam logic [2:0] OP_FIN   = 3'd4;
  localparam logic [2:0] OP_OUT   = 3'd5;

  // quarter steps of one G
  localparam logic [1:0] Q_A0 = 2'd0;
  localparam logic [1:0] Q_C0 = 2'd1;
  localparam logic [1:0] Q_A1 = 2'd2;
  localparam logic [1:0] Q_C1 = 2'd3;

  // row rotation patterns
  localparam logic [1:0] RR_NONE   = 2'd0;
  localparam logic [1:0] RR_UNI    = 2'd1;
  localparam logic [1:0] RR_DIAG   = 2'd2;
  localparam logic [1:0] RR_UNDIAG = 2'd3;

  // jump conditions
  localparam logic [2:0] J_NEXT  = 3'd0;
  localparam logic [2:0] J_GOTO  = 3'd1;
  localparam logic [2:0] J_LOOP  = 3'd2;
  localparam logic [2:0] J_START = 3'd3;
  localparam logic [2:0] J_FIN   = 3'd4;
  localparam logic [2:0] J_OUT   = 3'd5;

  localparam logic [PC_W-1:0] PC_WAIT      = 6'd0;
  localparam logic [PC_W-1:0] PC_LOAD      = 6'd1;
  localparam logic [PC_W-1:0] PC_INIT      = 6'd2;
  localparam logic [PC_W-1:0] PC_ROUND     = 6'd3;
  localparam logic [PC_W-1:0] PC_ROUND_END = 6'd34;
  localparam logic [PC_W-1:0] PC_FIN       = 6'd35;
  localparam logic [PC_W-1:0] PC_OUT       = 6'd36;

  typedef struct packed {
    logic [2:0]      op;
    logic [1:0]      qsel;
    logic [1:0]      rrot;
    logic            mperm;
    logic [2:0]      jc;
    logic [PC_W-1:0] target;
  } ucw_t;

  typedef logic [15:0][31:0] vec16_t;

  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    logic [PC_W-1:0] rel;
    w = '{op: OP_WAIT, qsel: Q_A0, rrot: RR_NONE, mperm: 1'b0, jc: J_GOTO, target: PC_WAIT};
    rel = pc - PC_ROUND;
    case (pc)
      PC_WAIT: begin
        w.jc = J_START;
      end
      PC_LOAD: begin
        w.op = OP_LOAD;
        w.jc = J_LOOP;
        w.target = PC_LOAD;
      end
      PC_INIT: begin
        w.op = OP_INIT;
        w.jc = J_NEXT;
      end
      PC_FIN: begin
        w.op = OP_FIN;
        w.jc = J_FIN;
      end
      PC_OUT: begin
        w.op = OP_OUT;
        w.jc = J_OUT;
        w.target = PC_WAIT;
      end
      default: begin
        if (pc >= PC_ROUND && pc <= PC_ROUND_END) begin
          w.op = OP_ROUND;
          w.qsel = rel[1:0];
          w.jc = J_NEXT;
          if (rel[1:0] == Q_C1) begin
            case (rel[4:2])
              3'd3:    w.rrot = RR_DIAG;
              3'd7:    w.rrot = RR_UNDIAG;
              default: w.rrot = RR_UNI;
            endcase
          end
          if (pc == PC_ROUND_END) begin
            w.mperm = 1'b1;
            w.jc = J_LOOP;
            w.target = PC_ROUND;
          end
        end
      end
    endcase
    return w;
  endfunction

  // left rotation of one state row, per pattern
  function automatic logic [1:0] rot_amt(input logic [1:0] rr, input logic [1:0] row);
    logic [1:0] a;
    case (rr)
      RR_UNI:    a = 2'd1;
      RR_DIAG:   a = row + 2'd1;
      RR_UNDIAG: a = 2'd1 - row;
      default:   a = 2'd0;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### rtl/core/blake3_chained_stream_hash_core.sv
`timescale 1ns / 1ps
// Chained stream hash core: 7-round compression on one shared quarter-G unit,
// run by a microcode ROM. Depends on b3csh_pkg and b3csh_ram.
//
// Usage:
//   in_*  : one transaction per step. in_tdata = message byte, in_tuser = byte
//           present, in_tlast = end of message. Steps with neither flag are no-ops.
//   out_* : one digest per ended message; out_tuser = poisoned.
//   cfg_* : register writes, taken at any edge with cfg_we high; write only
//           while the core is idle.
// Timing:
//   A byte that fits the block buffer is written straight into it. A byte arriving
//   on a full buffer, and each end of an unpoisoned message, runs one compression
//   (buffer reads into the message register, init, the quarter-G steps of all 7
//   rounds, finalize); in_tready is low meanwhile. The compression unit is the
//   limit. End of message to out_tvalid: the final compression, after a full
//   block if one waits; a poisoned message goes straight to the output step.
//   A pending digest waits in the output register while new bytes are taken;
//   a second digest waits in the sequencer until the receiver takes the first.
// Reset: synchronous, active low; no message open, registers to defaults
//   (digest_bytes 32, others 0). No clearing pass is needed.
module blake3_chained_stream_hash_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  logic                            in_tuser,   // [0] has_byte
  input  logic                            in_tlast,   // end_of_message
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [255:0]                    out_tdata,  // digest_0..digest_3, 64b each
  output logic                            out_tuser,  // [0] poisoned
  input  logic                            cfg_we,
  input  logic [b3csh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [b3csh_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import b3csh_pkg::*;

  // configuration
  logic [63:0]      domain_word_01_r, domain_word_23_r, domain_word_45_r;
  logic [31:0]      domain_word_6_r;
  logic [7:0]       domain_length_r;
  logic [DGB_W-1:0] digest_bytes_r;

  // sequencer and message state
  logic [PC_W-1:0]   pc_r, pc_nxt, wait_pc;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, loop_lim;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_eff;
  logic              open_r, open_nxt;
  logic              poison_r, poison_nxt, poison_eff;
  logic              final_r, final_nxt;
  logic              eom_pend_r, eom_pend_nxt;
  logic [7:0]        pend_byte_r, pend_byte_nxt;
  logic [7:0][31:0]  cv_r, cv_nxt, cv_open;
  vec16_t            v_r, v_nxt, vq;
  vec16_t            m_r, m_nxt, m_rot;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [255:0]      out_tdata_r, out_tdata_nxt, digest_kept;
  logic              out_tuser_r, out_tuser_nxt;

  ucw_t              uw;
  logic              in_act, absorb, full, out_free;
  logic              ram_we;
  logic [BLK_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata, ram_rdata, load_byte;
  logic [519:0]      ld_shift;
  logic [223:0]      dom;
  logic [DGB_W-1:0]  keep;
  logic [31:0]       qa, qb, qc, qd;

  assign uw = ucode(pc_r);

  assign in_tready  = (uw.op == OP_WAIT);
  assign in_act     = in_tvalid && in_tready && (in_tuser || in_tlast);
  assign poison_eff = open_r ? poison_r : (domain_length_r > 8'(DOMAIN_MAX));
  assign fill_eff   = open_r ? fill_r : '0;
  assign absorb     = in_tuser && !poison_eff;
  assign full       = (fill_eff == FILL_W'(BLOCK_BYTES));
  assign out_free   = !out_tvalid_r || out_tready;
  assign loop_lim   = (uw.op == OP_LOAD) ? CNT_W'(BLOCK_BYTES) : CNT_W'(ROUNDS - 1);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  b3csh_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[BLK_AW-1:0]),
    .rdata (ram_rdata)
  );

  // chain value at message open
  assign dom = {domain_word_6_r, domain_word_45_r, domain_word_23_r, domain_word_01_r};
  always_comb begin
    cv_open = '0;
    for (int i = 0; i < DOMAIN_MAX; i++) begin
      if (8'(i) < domain_length_r) begin
        cv_open[i / 4][8 * (i % 4) +: 8] = dom[8 * i +: 8];
      end
    end
    cv_open[7] = 32'(domain_length_r);
  end

  // truncated digest
  assign keep = (digest_bytes_r > DGB_W'(DIGEST_MAX)) ? DGB_W'(DIGEST_MAX) : digest_bytes_r;
  always_comb begin
    digest_kept = cv_r;
    for (int j = 0; j < DIGEST_MAX; j++) begin
      if (DGB_W'(j) >= keep) begin
        digest_kept[8 * j +: 8] = 8'h00;
      end
    end
  end

  // buffer byte into message register, zero past fill
  assign load_byte = (CNT_W'(cnt_r - 1'b1) < fill_r) ? ram_rdata : 8'h00;
  assign ld_shift  = {load_byte, m_r};
  assign m_rot     = {m_r[1:0], m_r[15:2]};

  // quarter-G unit on column 0 (v0, v4, v8, v12)
  always_comb begin
    qa = v_r[0];
    qb = v_r[4];
    qc = v_r[8];
    qd = v_r[12];
    case (uw.qsel)
      Q_A0: begin
        qa = v_r[0] + v_r[4] + m_r[0];
        qd = rotr32(v_r[12] ^ qa, 16);
      end
      Q_C0: begin
        qc = v_r[8] + v_r[12];
        qb = rotr32(v_r[4] ^ qc, 12);
      end
      Q_A1: begin
        qa = v_r[0] + v_r[4] + m_r[1];
        qd = rotr32(v_r[12] ^ qa, 8);
      end
      Q_C1: begin
        qc = v_r[8] + v_r[12];
        qb = rotr32(v_r[4] ^ qc, 7);
      end
      default: ;
    endcase
    vq = v_r;
    vq[0] = qa;
    vq[4] = qb;
    vq[8] = qc;
    vq[12] = qd;
  end

  always_comb begin
    logic [1:0] amt;
    logic [1:0] col;
    pc_nxt        = pc_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    open_nxt      = open_r;
    poison_nxt    = poison_r;
    final_nxt     = final_r;
    eom_pend_nxt  = eom_pend_r;
    pend_byte_nxt = pend_byte_r;
    cv_nxt        = cv_r;
    v_nxt         = v_r;
    m_nxt         = m_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    ram_we        = 1'b0;
    ram_waddr     = fill_eff[BLK_AW-1:0];
    ram_wdata     = in_tdata;
    wait_pc       = pc_r;
    amt           = '0;
    col           = '0;

    case (uw.op)
      OP_WAIT: begin
        if (in_act) begin
          open_nxt   = !in_tlast;
          poison_nxt = poison_eff;
          fill_nxt   = fill_eff;
          if (!open_r) begin
            cv_nxt = poison_eff ? '0 : cv_open;
          end
          if (absorb && !full) begin
            ram_we   = 1'b1;
            fill_nxt = fill_eff + 1'b1;
          end
          if (absorb && full) begin
            pend_byte_nxt = in_tdata;
            eom_pend_nxt  = in_tlast;
            final_nxt     = 1'b0;
            wait_pc       = PC_LOAD;
          end else if (in_tlast && poison_eff) begin
            wait_pc = PC_OUT;
          end else if (in_tlast) begin
            final_nxt = 1'b1;
            wait_pc   = PC_LOAD;
          end
        end
      end
      OP_LOAD: begin
        if (cnt_r != '0) begin
          m_nxt = ld_shift[519:8];
        end
      end
      OP_INIT: begin
        for (int i = 0; i < 8; i++) begin
          v_nxt[i] = cv_r[i];
        end
        for (int i = 0; i < 4; i++) begin
          v_nxt[8 + i] = IV[i];
        end
        v_nxt[12] = '0;
        v_nxt[13] = '0;
        v_nxt[14] = 32'(fill_r);
        v_nxt[15] = final_r ? FLAG_ROOT : '0;
      end
      OP_ROUND: begin
        for (int r = 0; r < 4; r++) begin
          amt = rot_amt(uw.rrot, 2'(r));
          for (int j = 0; j < 4; j++) begin
            col = 2'(j) + amt;
            v_nxt[4 * r + j] = vq[{2'(r), col}];
          end
        end
        if (uw.qsel == Q_C1) begin
          m_nxt = m_rot;
          if (uw.mperm) begin
            for (int i = 0; i < 16; i++) begin
              m_nxt[i] = m_rot[PERM[i]];
            end
          end
        end
      end
      OP_FIN: begin
        for (int i = 0; i < 8; i++) begin
          cv_nxt[i] = v_r[i] ^ v_r[i + 8];
        end
        if (!final_r) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = pend_byte_r;
          fill_nxt  = FILL_W'(1);
          if (eom_pend_r) begin
            final_nxt    = 1'b1;
            eom_pend_nxt = 1'b0;
          end
        end
      end
      OP_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = poison_r ? '0 : digest_kept;
          out_tuser_nxt  = poison_r;
        end
      end
      default: ;
    endcase

    case (uw.jc)
      J_NEXT: pc_nxt = pc_r + 1'b1;
      J_GOTO: pc_nxt = uw.target;
      J_LOOP: begin
        if (cnt_r == loop_lim) begin
          cnt_nxt = '0;
          pc_nxt  = pc_r + 1'b1;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          pc_nxt  = uw.target;
        end
      end
      J_START: pc_nxt = wait_pc;
      J_FIN: begin
        if (final_r) begin
          pc_nxt = PC_OUT;
        end else if (eom_pend_r) begin
          pc_nxt = PC_LOAD;
        end else begin
          pc_nxt = PC_WAIT;
        end
      end
      J_OUT: pc_nxt = out_free ? uw.target : pc_r;
      default: pc_nxt = PC_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      domain_word_01_r <= '0;
      domain_word_23_r <= '0;
      domain_word_45_r <= '0;
      domain_word_6_r  <= '0;
      domain_length_r  <= '0;
      digest_bytes_r   <= DGB_W'(DIGEST_MAX);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DOMAIN_01: domain_word_01_r <= cfg_wdata;
        REG_DOMAIN_23: domain_word_23_r <= cfg_wdata;
        REG_DOMAIN_45: domain_word_45_r <= cfg_wdata;
        REG_DOMAIN_6:  domain_word_6_r  <= cfg_wdata[31:0];
        REG_DOM_LEN:   domain_length_r  <= cfg_wdata[7:0];
        REG_DGST_LEN:  digest_bytes_r   <= cfg_wdata[DGB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= PC_WAIT;
      cnt_r        <= '0;
      fill_r       <= '0;
      open_r       <= 1'b0;
      poison_r     <= 1'b0;
      final_r      <= 1'b0;
      eom_pend_r   <= 1'b0;
      cv_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      pc_r         <= pc_nxt;
      cnt_r        <= cnt_nxt;
      fill_r       <= fill_nxt;
      open_r       <= open_nxt;
      poison_r     <= poison_nxt;
      final_r      <= final_nxt;
      eom_pend_r   <= eom_pend_nxt;
      cv_r         <= cv_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_byte_r <= pend_byte_nxt;
    v_r         <= v_nxt;
    m_r         <= m_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(BLOCK_BYTES))
    else $error("fill count past block size");

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == OP_WAIT) |-> (cnt_r == '0))
    else $error("loop counter not cleared on return to wait");

  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == OP_FIN && final_r) |=> (pc_r == PC_OUT))
    else $error("final compression did not go to output step");

  a_poison_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r) |-> (out_tdata_r == '0))
    else $error("poisoned digest not zero");

  a_no_write_load: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == OP_LOAD || uw.op == OP_ROUND) |-> !ram_we)
    else $error("buffer written during compression");

endmodule

### rtl/core/b3csh_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module b3csh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/tb_blake3_chained_stream_hash_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for blake3_chained_stream_hash_core: streams messages in, predicts
// each digest with a behavioral chained 7-round compression, checks results in order.
// Depends on b3csh_pkg and the core RTL.
module tb_blake3_chained_stream_hash_core;
  import b3csh_pkg::*;

  localparam int          CLK_HALF      = 10;
  localparam int          STALL_LIMIT   = 20000;
  localparam int          SETTLE_CYCLES = 600;
  localparam int          HOLD_CYCLES   = 4000;
  localparam int          MIX_ROUNDS    = 7;
  localparam int          FULL_BLOCK    = 64;
  localparam int          DOMAIN_LIMIT  = 28;
  localparam int          DIGEST_FULL   = 32;
  localparam logic [31:0] ROOT_FLAG     = 32'd8;
  localparam logic [31:0] HASH_IV [4]   = '{32'h6A09E667, 32'hBB67AE85,
                                            32'h3C6EF372, 32'hA54FF53A};
  localparam int          WORD_SHUF [16] = '{2, 6, 3, 10, 7, 0, 4, 13,
                                             1, 11, 12, 5, 9, 14, 15, 8};

  typedef struct packed {
    logic [255:0] digest;
    logic         poisoned;
  } digest_rec_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tuser;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [255:0]          out_tdata;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  blake3_chained_stream_hash_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // register shadow
  logic [63:0] dom01, dom23, dom45;
  logic [31:0] dom6;
  logic [7:0]  dom_len;
  logic [5:0]  dgst_len;

  // hash state shadow
  logic [31:0] hash_cv [8];
  logic [31:0] cv_work [16];
  logic [7:0]  blk_buf [64];
  int unsigned blk_fill;
  bit          msg_open;
  bit          msg_poison;

  digest_rec_t digest_q [$];
  digest_rec_t want;

  int errors;
  int bytes_sent;
  int steps_sent;
  int msgs_sent;
  int digests_seen;
  int poisoned_seen;
  int stall_count;
  int hold_left;
  int send_idle_pct;
  int recv_idle_pct;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void g_mix(input int a, input int b, input int c, input int d,
                                input logic [31:0] x, input logic [31:0] y);
    cv_work[a] = cv_work[a] + cv_work[b] + x;
    cv_work[d] = ror32(cv_work[d] ^ cv_work[a], 16);
    cv_work[c] = cv_work[c] + cv_work[d];
    cv_work[b] = ror32(cv_work[b] ^ cv_work[c], 12);
    cv_work[a] = cv_work[a] + cv_work[b] + y;
    cv_work[d] = ror32(cv_work[d] ^ cv_work[a], 8);
    cv_work[c] = cv_work[c] + cv_work[d];
    cv_work[b] = ror32(cv_work[b] ^ cv_work[c], 7);
  endfunction

  // counter is always 0; bytes at or past len read as zero
  function automatic void compress_block(input int unsigned len, input logic [31:0] flags);
    logic [31:0] m [16];
    logic [31:0] t [16];
    int i, r, b;
    for (i = 0; i < 16; i++) begin
      m[i] = '0;
      for (b = 3; b >= 0; b--)
        m[i] = {m[i][23:0], (4 * i + b < len) ? blk_buf[4 * i + b] : 8'h00};
    end
    for (i = 0; i < 8; i++) cv_work[i] = hash_cv[i];
    for (i = 0; i < 4; i++) cv_work[8 + i] = HASH_IV[i];
    cv_work[12] = '0;
    cv_work[13] = '0;
    cv_work[14] = len;
    cv_work[15] = flags;
    for (r = 0; r < MIX_ROUNDS; r++) begin
      g_mix(0, 4, 8, 12, m[0], m[1]);
      g_mix(1, 5, 9, 13, m[2], m[3]);
      g_mix(2, 6, 10, 14, m[4], m[5]);
      g_mix(3, 7, 11, 15, m[6], m[7]);
      g_mix(0, 5, 10, 15, m[8], m[9]);
      g_mix(1, 6, 11, 12, m[10], m[11]);
      g_mix(2, 7, 8, 13, m[12], m[13]);
      g_mix(3, 4, 9, 14, m[14], m[15]);
      for (i = 0; i < 16; i++) t[i] = m[WORD_SHUF[i]];
      for (i = 0; i < 16; i++) m[i] = t[i];
    end
    for (i = 0; i < 8; i++) hash_cv[i] = cv_work[i] ^ cv_work[i + 8];
  endfunction

  function automatic logic [7:0] dom_byte(input int i);
    logic [63:0] w;
    if (i < 8) w = dom01;
    else if (i < 16) w = dom23;
    else if (i < 24) w = dom45;
    else w = {32'h0, dom6};
    return w[8 * (i % 8) +: 8];
  endfunction

  function automatic void open_message();
    int i;
    msg_open   = 1'b1;
    blk_fill   = 0;
    msg_poison = dom_len > DOMAIN_LIMIT;
    for (i = 0; i < 8; i++) hash_cv[i] = '0;
    if (!msg_poison) begin
      for (i = 0; i < DOMAIN_LIMIT; i++)
        if (i < dom_len) hash_cv[i / 4] |= {24'h0, dom_byte(i)} << (8 * (i % 4));
      hash_cv[7] = {24'h0, dom_len};
    end
  endfunction

  // advances the shadow by one transaction; returns 1 when a digest is due
  function automatic bit hash_step(input logic [7:0] b, input bit has, input bit eom,
                                   output digest_rec_t r);
    logic [255:0] full;
    int unsigned  keep;
    int           i;
    r = '0;
    if (!has && !eom) return 1'b0;
    if (!msg_open) open_message();
    if (has && !msg_poison) begin
      if (blk_fill >= FULL_BLOCK) begin
        compress_block(FULL_BLOCK, '0);
        blk_fill = 0;
      end
      blk_buf[blk_fill] = b;
      blk_fill++;
    end
    if (!eom) return 1'b0;
    msg_open = 1'b0;
    if (msg_poison) begin
      r.poisoned = 1'b1;
      return 1'b1;
    end
    compress_block(blk_fill, ROOT_FLAG);
    keep = (dgst_len > DIGEST_FULL) ? DIGEST_FULL : dgst_len;
    for (i = 0; i < 8; i++) full[32 * i +: 32] = hash_cv[i];
    for (i = 0; i < DIGEST_FULL; i++)
      if (i >= keep) full[8 * i +: 8] = 8'h00;
    r.digest = full;
    return 1'b1;
  endfunction

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        $error("digest transaction with none outstanding");
        errors++;
      end else begin
        want = digest_q.pop_front();
        for (int k = 0; k < 4; k++)
          if (out_tdata[64 * k +: 64] !== want.digest[64 * k +: 64]) begin
            $error("digest_%0d: expected %h, got %h", k, want.digest[64 * k +: 64],
                   out_tdata[64 * k +: 64]);
            errors++;
          end
        if (out_tuser !== want.poisoned) begin
          $error("poisoned: expected %0b, got %0b", want.poisoned, out_tuser);
          errors++;
        end
        digests_seen++;
        if (want.poisoned) poisoned_seen++;
      end
    end
  end

  initial begin
    stall_count = 0;
    while (stall_count < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_count = 0;
      else stall_count++;
    end
    $display("blake3_chained_stream_hash_core test failed");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_DOMAIN_01: dom01 = val;
      REG_DOMAIN_23: dom23 = val;
      REG_DOMAIN_45: dom45 = val;
      REG_DOMAIN_6:  dom6 = val[31:0];
      REG_DOM_LEN:   dom_len = val[7:0];
      REG_DGST_LEN:  dgst_len = val[5:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input logic [7:0] b, input bit has, input bit eom);
    digest_rec_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= has;
    in_tlast  <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (hash_step(b, has, eom, r)) digest_q.push_back(r);
    if (has || eom) steps_sent++;
    if (has) bytes_sent++;
    if (eom) msgs_sent++;
  endtask

  // stop offering, let all digests drain, then give a running compression time to end
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_message(input int nbytes, input bit end_with_byte, input int noise_pct);
    int k;
    for (k = 0; k < nbytes; k++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, end_with_byte && (k == nbytes - 1));
    end
    if (nbytes == 0 || !end_with_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  function automatic int pick_msg_len();
    int sel;
    int edges [5] = '{63, 64, 65, 128, 129};
    sel = $urandom_range(0, 99);
    if (sel < 50) return $urandom_range(0, 6);
    if (sel < 75) return $urandom_range(7, 30);
    if (sel < 90) return edges[$urandom_range(0, 4)];
    return $urandom_range(31, 100);
  endfunction

  task automatic randomize_config();
    int sel;
    write_reg(REG_DOMAIN_01, {$urandom, $urandom});
    write_reg(REG_DOMAIN_23, {$urandom, $urandom});
    write_reg(REG_DOMAIN_45, {$urandom, $urandom});
    write_reg(REG_DOMAIN_6, {32'h0, $urandom});
    sel = $urandom_range(0, 99);
    if (sel < 70) write_reg(REG_DOM_LEN, 64'($urandom_range(0, DOMAIN_LIMIT)));
    else if (sel < 78) write_reg(REG_DOM_LEN, 64'd0);
    else if (sel < 86) write_reg(REG_DOM_LEN, 64'(DOMAIN_LIMIT));
    else if (sel < 93) write_reg(REG_DOM_LEN, 64'(DOMAIN_LIMIT + 1));
    else write_reg(REG_DOM_LEN, 64'($urandom_range(DOMAIN_LIMIT + 2, 255)));
    sel = $urandom_range(0, 99);
    if (sel < 50) write_reg(REG_DGST_LEN, 64'(DIGEST_FULL));
    else if (sel < 60) write_reg(REG_DGST_LEN, 64'd0);
    else if (sel < 85) write_reg(REG_DGST_LEN, 64'($urandom_range(1, DIGEST_FULL - 1)));
    else write_reg(REG_DGST_LEN, 64'($urandom_range(DIGEST_FULL + 1, 63)));
  endtask

  task automatic test_defaults();
    send_item(8'h3C, 1'b0, 1'b0);  // no-op step before any message
    send_item(8'h00, 1'b0, 1'b1);  // empty message
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);  // byte and end together
    drain();
  endtask

  task automatic test_domain_extremes();
    write_reg(REG_DOMAIN_01, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_DOMAIN_23, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_DOMAIN_45, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_DOMAIN_6, 64'h0000_0000_FFFF_FFFF);
    write_reg(REG_DOM_LEN, 64'(DOMAIN_LIMIT));
    write_reg(REG_DGST_LEN, 64'd63);  // saturates to full digest
    send_item(8'hA5, 1'b1, 1'b0);
    send_item(8'h5A, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    drain();
    write_reg(REG_DGST_LEN, 64'd0);
    send_item(8'h00, 1'b0, 1'b1);
    drain();
    write_reg(REG_DGST_LEN, 64'd1);
    send_item(8'h7E, 1'b1, 1'b1);
    drain();
    write_reg(REG_DOM_LEN, 64'(DOMAIN_LIMIT + 1));  // poisoned, bytes ignored
    send_item(8'h11, 1'b1, 1'b0);
    send_item(8'h22, 1'b1, 1'b0);
    send_item(8'h33, 1'b1, 1'b1);
    drain();
    write_reg(REG_DOM_LEN, 64'd255);
    send_item(8'hFF, 1'b0, 1'b1);
    drain();
  endtask

  // domain is latched at message open, digest length at message end
  task automatic test_late_config();
    write_reg(REG_DOM_LEN, 64'd5);
    write_reg(REG_DGST_LEN, 64'(DIGEST_FULL));
    send_item(8'hC3, 1'b1, 1'b0);
    drain();
    write_reg(REG_DOMAIN_01, 64'h0F1E_2D3C_4B5A_6978);
    write_reg(REG_DOM_LEN, 64'd40);
    write_reg(REG_DGST_LEN, 64'd16);
    send_item(8'h3C, 1'b1, 1'b1);
    drain();
    send_item(8'h00, 1'b0, 1'b1);
    drain();
    write_reg(REG_DOM_LEN, 64'd3);
    write_reg(REG_DGST_LEN, 64'(DIGEST_FULL));
  endtask

  // long output hold-off while short messages keep coming, so the input backs up
  task automatic test_backpressure();
    int n;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    for (n = 0; n < 6; n++)
      send_message($urandom_range(0, 3), 1'($urandom_range(0, 1)), 0);
    drain();
  endtask

  task automatic test_random_traffic(input int n_steps, input int n_msgs);
    int start_steps;
    int start_msgs;
    drain();
    randomize_config();
    start_steps = steps_sent;
    start_msgs  = msgs_sent;
    while (steps_sent - start_steps < n_steps || msgs_sent - start_msgs < n_msgs)
      send_message(pick_msg_len(), 1'($urandom_range(0, 1)), 5);
    drain();
  endtask

  initial begin
    int ph;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    in_tlast      = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    errors        = 0;
    bytes_sent    = 0;
    steps_sent    = 0;
    msgs_sent     = 0;
    digests_seen  = 0;
    poisoned_seen = 0;
    hold_left     = 0;
    dom01         = '0;
    dom23         = '0;
    dom45         = '0;
    dom6          = '0;
    dom_len       = '0;
    dgst_len      = 6'(DIGEST_FULL);
    blk_fill      = 0;
    msg_open      = 1'b0;
    msg_poison    = 1'b0;
    for (int i = 0; i < 8; i++) hash_cv[i] = '0;
    for (int i = 0; i < FULL_BLOCK; i++) blk_buf[i] = '0;
    send_idle_pct = 25;
    recv_idle_pct = 54;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_domain_extremes();
    test_late_config();
    test_backpressure();
    for (ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 25;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      test_random_traffic(60, 3);
    end

    drain();
    errors += digest_q.size();
    $display("Covered %0d messages (%0d digests checked, %0d poisoned), %0d bytes",
             msgs_sent, digests_seen, poisoned_seen, bytes_sent);
    $display("over three idle mixes, block-edge lengths, domain and digest-size extremes");
    if (errors == 0) begin
      $display("blake3_chained_stream_hash_core test passed");
    end else begin
      $display("blake3_chained_stream_hash_core test failed");
    end
    $finish;
  end

endmodule

### blake3_chained_stream_hash_core.f
rtl/core/b3csh_pkg.sv
rtl/core/b3csh_ram.sv
rtl/core/blake3_chained_stream_hash_core.sv
tb/tb_blake3_chained_stream_hash_core.sv
